@@ rtl/u8cols_pkg.sv @@
// Shared types and constants for the UTF-8 text to column decoder.
// No dependencies; imported by utf8_text_to_columns.

package u8cols_pkg;

  // Hard cap on columns per text, on top of the programmable width
  localparam int unsigned COLUMN_LIMIT = 4096;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 21;
  localparam int unsigned ColW    = 13;
  localparam int unsigned LenW    = 3;
  localparam int unsigned SeenW   = 2;
  localparam int unsigned MaxRes  = 4;
  localparam int unsigned SlotW   = $clog2(MaxRes);
  localparam int unsigned CntW    = $clog2(MaxRes + 1);

  // Stream word widths: code_point and column packed, padded to bytes
  localparam int unsigned OutBits  = CpW + ColW;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  localparam logic [ColW-1:0] ColLimit   = ColW'(COLUMN_LIMIT);
  localparam logic [ColW-1:0] ColReset   = ColW'(80);

  // Byte classes
  localparam logic [1:0] ContTag  = 2'b10;
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [4:0] Lead4Tag = 5'b11110;

  localparam logic [ByteW-1:0] TermByte = 8'h00;
  localparam logic [CpW-1:0]   TabCp    = CpW'(8'h09);
  localparam logic [CpW-1:0]   SpaceCp  = CpW'(8'h20);

  // One result word
  typedef struct packed {
    logic            end_rpt;
    logic [ColW-1:0] column;
    logic [CpW-1:0]  code_point;
  } result_t;

endpackage

@@ rtl/utf8_text_to_columns.sv @@
// UTF-8 text to column decoder, top level.
// Depends on u8cols_pkg for widths, byte classes and the result type.
//
// Usage:
//   s_axis carries text bytes; a zero byte ends a text. Each accepted byte
//   yields zero to four result words on m_axis: decoded characters with
//   their column, and on the terminator an end report holding the count.
//   tlast marks the last word caused by one input byte.
//   cfg_* writes max_columns; write it only while the block is idle.
// Timing:
//   A byte is decoded in the cycle it is accepted and its results appear
//   in the result buffer in the next cycle. The buffer drains one word per
//   cycle while m_axis_tready is high; s_axis waits for its last word, so a
//   byte with zero or one result lets the next byte in every cycle while
//   m_axis_tready is high. The buffer and its read pointer set the rate.
// Reset:
//   rst_ni clears the decode state and column count, empties the buffer
//   and sets max_columns to 80.
// Stall:
//   When m_axis_tready is low the buffered words hold and s_axis_tready
//   drops until the final buffered word is taken.

module utf8_text_to_columns (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: [7:0] text_byte
  input  logic [u8cols_pkg::ByteW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: [20:0] code_point, [33:21] column, rest zero
  output logic [u8cols_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: [0] end_report
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [u8cols_pkg::ColW-1:0]    cfg_data_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o
);

  import u8cols_pkg::*;

  function automatic logic [CpW-1:0] tab_fix(input logic [CpW-1:0] cp);
    tab_fix = (cp == TabCp) ? SpaceCp : cp;
  endfunction

  // Configuration and decode state
  logic [ColW-1:0]  max_cols_q;
  logic [ByteW-1:0] lead_q, lead_d;
  logic [ByteW-1:0] pend_q [2];
  logic             pend_we0, pend_we1;
  logic [LenW-1:0]  exp_q, exp_d;
  logic [SeenW-1:0] seen_q, seen_d;
  logic [CpW-1:0]   pp_q, pp_d;
  logic [ColW-1:0]  col_q, col_d;

  // Result buffer
  result_t          slot_q [MaxRes];
  result_t          slot_d [MaxRes];
  logic [CntW-1:0]  rem_q, rem_d;
  logic [SlotW-1:0] rd_q;

  logic             in_acc, out_acc;
  logic [ColW-1:0]  limit;

  assign cfg_ready_o = 1'b1;
  assign limit = (max_cols_q > ColLimit) ? ColLimit : max_cols_q;

  // Output side: present the word under the read pointer
  assign m_axis_tvalid = (rem_q != '0);
  assign m_axis_tdata  = {(OutDataW - OutBits)'(0), slot_q[rd_q].column,
                          slot_q[rd_q].code_point};
  assign m_axis_tuser  = slot_q[rd_q].end_rpt;
  assign m_axis_tlast  = (rem_q == CntW'(1));
  assign out_acc       = m_axis_tvalid & m_axis_tready;

  // Accept a byte once the buffer empties this cycle
  assign s_axis_tready = (rem_q == '0) || ((rem_q == CntW'(1)) && m_axis_tready);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // Decode one byte against the current state
  always_comb begin
    logic [CntW-1:0]  k;
    logic [ColW-1:0]  col_v;
    logic [CpW-1:0]   pp_v;
    logic [ByteW-1:0] b;
    logic             done;
    logic [LenW-1:0]  nlen;

    b        = s_axis_tdata;
    k        = '0;
    col_v    = col_q;
    pp_v     = '0;
    done     = 1'b0;
    nlen     = LenW'(1);
    lead_d   = lead_q;
    exp_d    = exp_q;
    seen_d   = seen_q;
    pp_d     = pp_q;
    pend_we0 = 1'b0;
    pend_we1 = 1'b0;
    for (int i = 0; i < MaxRes; i++) begin
      slot_d[i] = '0;
    end

    if (exp_q != '0) begin
      if (b[7:6] == ContTag) begin
        // Continuation: extend the partial code point
        done = 1'b1;
        pp_v = {pp_q[CpW-7:0], b[5:0]};
        if ((LenW'(seen_q) + LenW'(1)) >= exp_q) begin
          if (col_v < limit) begin
            slot_d[k[SlotW-1:0]] = '{1'b0, col_v, tab_fix(pp_v)};
            k     = k + CntW'(1);
            col_v = col_v + ColW'(1);
          end
          lead_d = '0;
          exp_d  = '0;
          seen_d = '0;
          pp_d   = '0;
        end else begin
          // Buffer the byte in case the sequence is cancelled
          if (seen_q[0]) begin
            pend_we0 = 1'b1;
          end else begin
            pend_we1 = 1'b1;
          end
          seen_d = seen_q + SeenW'(1);
          pp_d   = pp_v;
        end
      end else begin
        // Cancel: emit the lead and buffered bytes raw
        if (col_v < limit) begin
          slot_d[k[SlotW-1:0]] = '{1'b0, col_v, tab_fix(CpW'(lead_q))};
          k     = k + CntW'(1);
          col_v = col_v + ColW'(1);
        end
        if ((seen_q >= SeenW'(2)) && (col_v < limit)) begin
          slot_d[k[SlotW-1:0]] = '{1'b0, col_v, tab_fix(CpW'(pend_q[0]))};
          k     = k + CntW'(1);
          col_v = col_v + ColW'(1);
        end
        if ((seen_q >= SeenW'(3)) && (col_v < limit)) begin
          slot_d[k[SlotW-1:0]] = '{1'b0, col_v, tab_fix(CpW'(pend_q[1]))};
          k     = k + CntW'(1);
          col_v = col_v + ColW'(1);
        end
        lead_d = '0;
        exp_d  = '0;
        seen_d = '0;
        pp_d   = '0;
      end
    end

    // Fresh byte: terminator, single-byte character or new lead
    if (!done) begin
      if (b == TermByte) begin
        slot_d[k[SlotW-1:0]] = '{1'b1, col_v, '0};
        k     = k + CntW'(1);
        col_v = '0;
      end else if (col_v < limit) begin
        priority if (!b[7]) begin
          nlen = LenW'(1);
        end else if (b[7:5] == Lead2Tag) begin
          nlen = LenW'(2);
        end else if (b[7:4] == Lead3Tag) begin
          nlen = LenW'(3);
        end else if (b[7:3] == Lead4Tag) begin
          nlen = LenW'(4);
        end else begin
          nlen = LenW'(1);
        end
        if (nlen == LenW'(1)) begin
          slot_d[k[SlotW-1:0]] = '{1'b0, col_v, tab_fix(CpW'(b))};
          k     = k + CntW'(1);
          col_v = col_v + ColW'(1);
        end else begin
          lead_d = b;
          exp_d  = nlen;
          seen_d = SeenW'(1);
          unique case (nlen)
            LenW'(2): pp_d = CpW'(b[4:0]);
            LenW'(3): pp_d = CpW'(b[3:0]);
            default:  pp_d = CpW'(b[2:0]);
          endcase
        end
      end
    end

    col_d = col_v;
    rem_d = k;
  end

  // Hold configuration and decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cols_q <= ColReset;
      lead_q     <= '0;
      exp_q      <= '0;
      seen_q     <= '0;
      pp_q       <= '0;
      col_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_cols_q <= cfg_data_i;
      end
      if (in_acc) begin
        lead_q <= lead_d;
        exp_q  <= exp_d;
        seen_q <= seen_d;
        pp_q   <= pp_d;
        col_q  <= col_d;
      end
    end
  end

  // Store continuation bytes of an open sequence
  always_ff @(posedge clk_i) begin
    if (in_acc && pend_we0) begin
      pend_q[0] <= s_axis_tdata;
    end
    if (in_acc && pend_we1) begin
      pend_q[1] <= s_axis_tdata;
    end
  end

  // Load result words on accept
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MaxRes; i++) begin
        slot_q[i] <= slot_d[i];
      end
    end
  end

  // Advance the buffer read pointer and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      rd_q  <= '0;
    end else if (in_acc) begin
      rem_q <= rem_d;
      rd_q  <= '0;
    end else if (out_acc) begin
      rem_q <= rem_q - CntW'(1);
      rd_q  <= rd_q + SlotW'(1);
    end
  end

endmodule
